[hw/rtl/pn_pkg.sv]
// Shared constants, command and beat types for the path normalizer.
package pn_pkg;

    localparam int PATH_CHARS = 256;
    localparam int MAX_SEGS   = 64;
    localparam int PTR_W      = $clog2(PATH_CHARS);
    localparam int SEG_W      = $clog2(MAX_SEGS);
    localparam int CNT_W      = SEG_W + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [PTR_W-1:0] KEEP_LIMIT = PTR_W'(PATH_CHARS - 1);
    localparam logic [PTR_W-1:0] KEEP_LAST  = PTR_W'(PATH_CHARS - 2);
    localparam logic [CNT_W-1:0] SEG_LIMIT  = CNT_W'(MAX_SEGS);

    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_PUSH,
        SEG_POP
    } seg_op_t;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        seg_op_t          op;
        logic [PTR_W-1:0] seg_b;
        logic [PTR_W-1:0] seg_l;
        logic             last;
    } cmd_t;

    typedef enum logic [2:0] {
        B_RUN,
        B_LEAD,
        B_SEGRD,
        B_CHARS,
        B_SEP
    } back_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } char_beat_t;

endpackage

[hw/rtl/pn_ifs.sv]
// Valid/ready channel interfaces for path characters and packed result words.
interface pn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pn_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        done_res;

    modport source (output valid, output word, output nbytes, output done_res, input ready);
    modport sink   (input valid, input word, input nbytes, input done_res, output ready);
endinterface

[hw/rtl/path_normalizer.sv]
// Top level of the path normalizer: front end, command queue, back end and packer.
//
//   port   | modport | carries                         | direction
//   -------+---------+---------------------------------+----------
//   chars  | sink    | ch[7:0], last                   | in
//   words  | source  | word[31:0], nbytes[2:0], done_res | out
//
// Characters enter at one per cycle, while the queue has room, into a two-entry command queue.
// The item flagged last then holds the back end until it has emitted
// the whole result, and longer while words is stalled;
// the front keeps taking characters until the queue fills.
// rst_n is asynchronous and active low; the stores need no clearing pass.
module path_normalizer (
    input  logic     clk,
    input  logic     rst_n,
    pn_in_if.sink    chars,
    pn_out_if.source words
);

    logic               q_push_valid;
    logic               q_push_ready;
    pn_pkg::cmd_t       q_push_cmd;
    logic               q_pop_valid;
    logic               q_pop_ready;
    pn_pkg::cmd_t       q_pop_cmd;
    pn_pkg::char_beat_t beat;
    logic               beat_take;

    pn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd)
    );

    pn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_cmd)
    );

    pn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_cmd   (q_pop_cmd),
        .beat      (beat),
        .take      (beat_take)
    );

    pn_pack u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (beat_take),
        .words (words)
    );

endmodule

[hw/rtl/pn_front.sv]
// Front end: tracks the open segment and turns each character into a command.
module pn_front (
    input  logic          clk,
    input  logic          rst_n,
    pn_in_if.sink         chars,
    output logic          push_valid,
    input  logic          push_ready,
    output pn_pkg::cmd_t  push_cmd
);

    logic [pn_pkg::PTR_W-1:0] wpos_reg, wpos_next;
    logic [pn_pkg::PTR_W-1:0] cbeg_reg, cbeg_next;
    logic [pn_pkg::PTR_W-1:0] clen_reg, clen_next;
    logic [1:0]               dot_reg,  dot_next;

    logic                     accept;
    logic                     keep;
    logic                     slash;
    logic                     grow;
    logic                     close_seg;
    logic [pn_pkg::PTR_W-1:0] seg_beg;
    logic [pn_pkg::PTR_W-1:0] seg_len;
    logic [1:0]               seg_dot;
    pn_pkg::seg_op_t          op;

    assign chars.ready = push_ready;
    assign push_valid  = chars.valid;
    assign accept      = chars.valid && push_ready;

    assign keep  = (chars.ch != pn_pkg::CH_NONE) && (wpos_reg < pn_pkg::KEEP_LIMIT);
    assign slash = keep && (chars.ch == pn_pkg::CH_SLASH);
    assign grow  = keep && !slash;
    assign close_seg = slash || chars.last;

    // Open segment as it stands after this character.
    always_comb
    begin
        seg_beg = cbeg_reg;
        seg_len = clen_reg;
        seg_dot = dot_reg;
        if (grow)
        begin
            if (clen_reg == '0)
                seg_beg = wpos_reg;
            if (chars.ch == pn_pkg::CH_DOT)
            begin
                if (clen_reg == '0)
                    seg_dot[0] = 1'b1;
                else if (clen_reg == pn_pkg::PTR_W'(1))
                    seg_dot[1] = 1'b1;
            end
            seg_len = clen_reg + pn_pkg::PTR_W'(1);
        end
    end

    always_comb
    begin
        if (!close_seg || seg_len == '0)
            op = pn_pkg::SEG_NONE;
        else if (seg_len == pn_pkg::PTR_W'(1) && seg_dot[0])
            op = pn_pkg::SEG_NONE;
        else if (seg_len == pn_pkg::PTR_W'(2) && seg_dot == 2'b11)
            op = pn_pkg::SEG_POP;
        else
            op = pn_pkg::SEG_PUSH;
    end

    always_comb
    begin
        wpos_next = chars.last ? '0 : wpos_reg + pn_pkg::PTR_W'(keep);
        cbeg_next = close_seg ? '0 : seg_beg;
        clen_next = close_seg ? '0 : seg_len;
        dot_next  = close_seg ? 2'b00 : seg_dot;
    end

    always_comb
    begin
        push_cmd.wr_en   = keep;
        push_cmd.wr_addr = wpos_reg;
        push_cmd.wr_data = chars.ch;
        push_cmd.op      = op;
        push_cmd.seg_b   = seg_beg;
        push_cmd.seg_l   = seg_len;
        push_cmd.last    = chars.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            cbeg_reg <= '0;
            clen_reg <= '0;
            dot_reg  <= 2'b00;
        end
        else if (accept)
        begin
            wpos_reg <= wpos_next;
            cbeg_reg <= cbeg_next;
            clen_reg <= clen_next;
            dot_reg  <= dot_next;
        end
    end

endmodule

[hw/rtl/pn_queue.sv]
// Short command queue between the front end and the back end.
module pn_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pn_pkg::cmd_t  push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pn_pkg::cmd_t  pop_cmd
);

    pn_pkg::cmd_t              slot_reg [pn_pkg::QDEPTH];
    logic [pn_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [pn_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [pn_pkg::QPTR_W:0]   cnt_reg,  cnt_next;
    logic                      push_fire;
    logic                      pop_fire;

    assign push_ready = (cnt_reg != pn_pkg::QDEPTH[pn_pkg::QPTR_W:0]);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next = push_fire ? wptr_reg + pn_pkg::QPTR_W'(1) : wptr_reg;
        rptr_next = pop_fire ? rptr_reg + pn_pkg::QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push_fire && !pop_fire)
            cnt_next = cnt_reg + (pn_pkg::QPTR_W + 1)'(1);
        else if (pop_fire && !push_fire)
            cnt_next = cnt_reg - (pn_pkg::QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pn_pkg::QDEPTH[pn_pkg::QPTR_W:0])
        else $error("queue count beyond depth");
`endif

endmodule

[hw/rtl/pn_back.sv]
// Back end: character and segment stores, and the byte sequencer for the result path.
module pn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  pn_pkg::cmd_t       pop_cmd,
    output pn_pkg::char_beat_t beat,
    input  logic               take
);

    logic [7:0]               char_mem  [pn_pkg::PATH_CHARS];
    logic [pn_pkg::PTR_W-1:0] segb_mem  [pn_pkg::MAX_SEGS];
    logic [pn_pkg::PTR_W-1:0] segl_mem  [pn_pkg::MAX_SEGS];

    pn_pkg::back_state_t      state_reg, state_next;
    logic [pn_pkg::CNT_W-1:0] total_reg;
    logic [pn_pkg::CNT_W-1:0] idx_reg;
    logic [pn_pkg::PTR_W-1:0] j_reg;
    logic [pn_pkg::PTR_W-1:0] n_reg;
    logic [pn_pkg::PTR_W-1:0] segb_reg;
    logic [pn_pkg::PTR_W-1:0] segl_reg;
    logic                     bv_reg;
    logic                     bconst_reg;
    logic                     bend_reg;
    logic [7:0]               rd_reg;

    logic                     pop_fire;
    logic                     can_issue;
    logic                     n_last;
    logic                     seg_end;
    logic                     last_seg;
    logic                     issue;
    logic                     issue_const;
    logic                     issue_end;
    logic [pn_pkg::PTR_W-1:0] rd_addr;
    logic                     stack_room;

    assign pop_fire   = pop_valid && pop_ready;
    assign can_issue  = !bv_reg || take;
    assign n_last     = (n_reg == pn_pkg::KEEP_LAST);
    assign seg_end    = ((j_reg + pn_pkg::PTR_W'(1)) == segl_reg);
    assign last_seg   = ((idx_reg + pn_pkg::CNT_W'(1)) == total_reg);
    assign rd_addr    = segb_reg + j_reg;
    assign stack_room = (total_reg < pn_pkg::SEG_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pn_pkg::B_RUN:
                if (pop_fire && pop_cmd.last)
                    state_next = pn_pkg::B_LEAD;
            pn_pkg::B_LEAD:
                if (can_issue)
                    state_next = (total_reg == '0) ? pn_pkg::B_RUN : pn_pkg::B_SEGRD;
            pn_pkg::B_SEGRD:
                state_next = pn_pkg::B_CHARS;
            pn_pkg::B_CHARS:
                if (can_issue)
                begin
                    if (n_last || (seg_end && last_seg))
                        state_next = pn_pkg::B_RUN;
                    else if (seg_end)
                        state_next = pn_pkg::B_SEP;
                end
            pn_pkg::B_SEP:
                if (can_issue)
                    state_next = n_last ? pn_pkg::B_RUN : pn_pkg::B_SEGRD;
            default:
                state_next = pn_pkg::B_RUN;
        endcase
    end

    always_comb
    begin
        pop_ready   = 1'b0;
        issue       = 1'b0;
        issue_const = 1'b0;
        issue_end   = 1'b0;
        unique case (state_reg)
            pn_pkg::B_RUN:
                pop_ready = 1'b1;
            pn_pkg::B_LEAD:
            begin
                issue       = can_issue;
                issue_const = 1'b1;
                issue_end   = (total_reg == '0);
            end
            pn_pkg::B_SEGRD:
                issue = 1'b0;
            pn_pkg::B_CHARS:
            begin
                issue     = can_issue;
                issue_end = n_last || (seg_end && last_seg);
            end
            pn_pkg::B_SEP:
            begin
                issue       = can_issue;
                issue_const = 1'b1;
                issue_end   = n_last;
            end
            default:
                issue = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pn_pkg::B_RUN;
            total_reg  <= '0;
            idx_reg    <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
            bv_reg     <= 1'b0;
            bconst_reg <= 1'b0;
            bend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (pop_fire)
            begin
                if (pop_cmd.op == pn_pkg::SEG_PUSH && stack_room)
                    total_reg <= total_reg + pn_pkg::CNT_W'(1);
                else if (pop_cmd.op == pn_pkg::SEG_POP && total_reg != '0)
                    total_reg <= total_reg - pn_pkg::CNT_W'(1);
            end
            else if (issue && issue_end)
                total_reg <= '0;

            if (state_reg == pn_pkg::B_LEAD && issue)
            begin
                n_reg   <= pn_pkg::PTR_W'(1);
                idx_reg <= '0;
            end
            else if (state_reg == pn_pkg::B_SEGRD)
                j_reg <= '0;
            else if (state_reg == pn_pkg::B_CHARS && issue)
            begin
                n_reg <= n_reg + pn_pkg::PTR_W'(1);
                j_reg <= j_reg + pn_pkg::PTR_W'(1);
            end
            else if (state_reg == pn_pkg::B_SEP && issue)
            begin
                n_reg   <= n_reg + pn_pkg::PTR_W'(1);
                idx_reg <= idx_reg + pn_pkg::CNT_W'(1);
            end

            // Hold the byte stage until the packer takes it.
            if (issue)
            begin
                bv_reg     <= 1'b1;
                bconst_reg <= issue_const;
                bend_reg   <= issue_end;
            end
            else if (take)
                bv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire && pop_cmd.wr_en)
            char_mem[pop_cmd.wr_addr] <= pop_cmd.wr_data;
        if (issue)
            rd_reg <= char_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire && pop_cmd.op == pn_pkg::SEG_PUSH && stack_room)
        begin
            segb_mem[total_reg[pn_pkg::SEG_W-1:0]] <= pop_cmd.seg_b;
            segl_mem[total_reg[pn_pkg::SEG_W-1:0]] <= pop_cmd.seg_l;
        end
        if (state_reg == pn_pkg::B_SEGRD)
        begin
            segb_reg <= segb_mem[idx_reg[pn_pkg::SEG_W-1:0]];
            segl_reg <= segl_mem[idx_reg[pn_pkg::SEG_W-1:0]];
        end
    end

    always_comb
    begin
        beat.valid = bv_reg;
        beat.data  = bconst_reg ? pn_pkg::CH_SLASH : rd_reg;
        beat.last  = bend_reg;
    end

`ifndef SYNTHESIS
    a_j_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pn_pkg::B_CHARS |-> j_reg < segl_reg)
        else $error("segment character index past segment length");

    a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bv_reg && !take |=> bv_reg)
        else $error("byte stage dropped an untaken byte");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= pn_pkg::SEG_LIMIT)
        else $error("segment count beyond stack depth");
`endif

endmodule

[hw/rtl/pn_pack.sv]
// Packs the byte stream into result words of up to four characters.
module pn_pack (
    input  logic               clk,
    input  logic               rst_n,
    input  pn_pkg::char_beat_t beat,
    output logic               take,
    pn_out_if.source           words
);

    logic [23:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        ov_reg;
    logic [31:0] word_reg;
    logic [2:0]  nb_reg;
    logic        done_reg;

    logic        out_free;
    logic        full;
    logic [31:0] merged;

    assign out_free = !ov_reg || words.ready;
    assign full     = beat.last || (cnt_reg == 2'd3);
    assign take     = beat.valid && (!full || out_free);
    assign merged   = {8'h00, acc_reg} | ({24'h000000, beat.data} << {cnt_reg, 3'b000});

    assign words.valid    = ov_reg;
    assign words.word     = word_reg;
    assign words.nbytes   = nb_reg;
    assign words.done_res = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= 2'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (take && full)
            begin
                acc_reg <= '0;
                cnt_reg <= 2'd0;
            end
            else if (take)
            begin
                acc_reg <= merged[23:0];
                cnt_reg <= cnt_reg + 2'd1;
            end

            if (take && full)
                ov_reg <= 1'b1;
            else if (words.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && full)
        begin
            word_reg <= merged;
            nb_reg   <= {1'b0, cnt_reg} + 3'd1;
            done_reg <= beat.last;
        end
    end

`ifndef SYNTHESIS
    a_nbytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (nb_reg != 3'd0) && (nb_reg <= 3'd4))
        else $error("result word with byte count out of range");
`endif

endmodule

[tb/sv/tb.sv]
// Testbench for path_normalizer: directed and random paths checked word by word.
module tb;

    localparam int KEEP_CHARS  = pn_pkg::PATH_CHARS - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_CYCLES  = 400;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        done_res;
    } path_word_t;

    logic clk;
    logic rst_n;

    pn_in_if  chars_if();
    pn_out_if words_if();

    path_normalizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .words (words_if)
    );

    // canonical path model state
    logic [7:0] kept_chars [pn_pkg::PATH_CHARS];
    int         stk_start [pn_pkg::MAX_SEGS];
    int         stk_len [pn_pkg::MAX_SEGS];
    int         stk_depth  = 0;
    int         kept_count = 0;
    int         open_start = 0;
    int         open_len   = 0;
    logic [1:0] open_dots  = 2'b00;

    path_word_t expected_words[$];
    int         fail_count   = 0;
    int         cycle_count  = 0;
    bit         word_taken   = 1'b0;
    bit         tx_idle      = 1'b1;
    bit         rx_idle      = 1'b1;
    int         hold_request = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void close_open_seg();
        if (open_len == 0)
            return;
        if (open_len == 1 && open_dots[0])
        begin
            // single dot: skip
        end
        else if (open_len == 2 && open_dots == 2'b11)
        begin
            if (stk_depth > 0)
                stk_depth--;
        end
        else if (stk_depth < pn_pkg::MAX_SEGS)
        begin
            stk_start[stk_depth] = open_start;
            stk_len[stk_depth]   = open_len;
            stk_depth++;
        end
        open_len   = 0;
        open_start = 0;
        open_dots  = 2'b00;
    endfunction

    // Advance the model by one character; on the final one queue the packed words.
    function automatic void canon_step(input logic [7:0] c, input logic fin);
        logic [7:0] text [pn_pkg::PATH_CHARS];
        int         n;
        int         nwords;
        int         cnt;
        path_word_t beat;
        n = 0;
        if (c != pn_pkg::CH_NONE && kept_count < KEEP_CHARS)
        begin
            kept_chars[kept_count] = c;
            if (c == pn_pkg::CH_SLASH)
                close_open_seg();
            else
            begin
                if (open_len == 0)
                    open_start = kept_count;
                if (c == pn_pkg::CH_DOT)
                begin
                    if (open_len == 0)
                        open_dots[0] = 1'b1;
                    else if (open_len == 1)
                        open_dots[1] = 1'b1;
                end
                open_len++;
            end
            kept_count++;
        end
        if (!fin)
            return;
        close_open_seg();
        text[n] = pn_pkg::CH_SLASH;
        n++;
        for (int i = 0; i < stk_depth && n < KEEP_CHARS; i++)
        begin
            for (int j = 0; j < stk_len[i] && n < KEEP_CHARS; j++)
            begin
                text[n] = kept_chars[stk_start[i] + j];
                n++;
            end
            if (i + 1 != stk_depth && n < KEEP_CHARS)
            begin
                text[n] = pn_pkg::CH_SLASH;
                n++;
            end
        end
        nwords = (n + 3) / 4;
        for (int k = 0; k < nwords; k++)
        begin
            cnt = n - 4 * k;
            if (cnt > 4)
                cnt = 4;
            beat.word = '0;
            for (int j = 0; j < cnt; j++)
                beat.word[8 * j +: 8] = text[4 * k + j];
            beat.nbytes   = cnt[2:0];
            beat.done_res = (k + 1 == nwords);
            expected_words.push_back(beat);
        end
        stk_depth  = 0;
        kept_count = 0;
        open_start = 0;
        open_len   = 0;
        open_dots  = 2'b00;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        path_word_t exp_w;
        word_taken = rst_n && words_if.valid && words_if.ready;
        if (word_taken)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h nbytes %0d done %0b", $time,
                         words_if.word, words_if.nbytes, words_if.done_res);
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (words_if.word !== exp_w.word)
                begin
                    $display("%0t: word expected %h got %h", $time, exp_w.word, words_if.word);
                    fail_count++;
                end
                if (words_if.nbytes !== exp_w.nbytes)
                begin
                    $display("%0t: nbytes expected %0d got %0d", $time, exp_w.nbytes,
                             words_if.nbytes);
                    fail_count++;
                end
                if (words_if.done_res !== exp_w.done_res)
                begin
                    $display("%0t: done_res expected %0b got %0b", $time, exp_w.done_res,
                             words_if.done_res);
                    fail_count++;
                end
            end
        end
    end

    // result receiver: random wait after each transaction while rx_idle is set, long hold on request
    initial
    begin : word_sink
        int wait_left;
        wait_left = 0;
        words_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                wait_left    = hold_request;
                hold_request = 0;
            end
            else if (word_taken)
                wait_left = rx_idle ? $urandom_range(0, 9) : 0;
            if (wait_left > 0)
            begin
                words_if.ready <= 1'b0;
                wait_left--;
            end
            else
                words_if.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_plain();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == pn_pkg::CH_SLASH || v == pn_pkg::CH_DOT);
        return v;
    endfunction

    function automatic char_q_t from_text(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Called and returns at a falling edge.
    task automatic push_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.ch    <= c;
        chars_if.last  <= fin;
        do
            @(posedge clk);
        while (!chars_if.ready);
        canon_step(c, fin);
        @(negedge clk);
    endtask

    task automatic push_path(input char_q_t p, input bit zero_end);
        for (int i = 0; i < p.size(); i++)
            push_char(p[i], !zero_end && i == p.size() - 1);
        if (zero_end || p.size() == 0)
            push_char(pn_pkg::CH_NONE, 1'b1);
    endtask

    task automatic wait_drain();
        chars_if.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        char_q_t p;
        push_path(p, 1'b1);
        push_path(from_text("/"), 1'b0);
        // pop on empty stack, slash run, dot skip, pop, dot-led name
        push_path(from_text("../a//./../.b"), 1'b0);
        // byte extremes, a zero inside a name, trailing single dot
        p = '{8'h01, 8'hFF, pn_pkg::CH_NONE, 8'h80, 8'h7F, pn_pkg::CH_SLASH, pn_pkg::CH_DOT};
        push_path(p, 1'b1);
    endtask

    // One name longer than the store: the output is cut and slashes past the end drop.
    task automatic test_full_store();
        char_q_t p;
        repeat (KEEP_CHARS + 3) p.push_back(rand_plain());
        p.push_back(pn_pkg::CH_SLASH);
        p.push_back(rand_plain());
        p.push_back(rand_plain());
        push_path(p, 1'b0);
    endtask

    task automatic test_full_stack();
        char_q_t p;
        repeat (pn_pkg::MAX_SEGS + 6)
        begin
            p.push_back(rand_plain());
            p.push_back(pn_pkg::CH_SLASH);
        end
        p.push_back(pn_pkg::CH_DOT);
        p.push_back(pn_pkg::CH_DOT);
        p.push_back(pn_pkg::CH_SLASH);
        p.push_back(rand_plain());
        push_path(p, 1'b0);
    endtask

    // Hold the receiver while paths stream in back to back, so the input stalls.
    task automatic test_backpressure();
        hold_request = 300;
        tx_idle = 1'b0;
        push_path(from_text("/usr/./lib/"), 1'b0);
        push_path(from_text("a/b/../c"), 1'b0);
        push_path(from_text("//x//y//"), 1'b1);
        push_path(from_text("/p/q/r/s/t"), 1'b0);
        tx_idle = 1'b1;
        wait_drain();
    endtask

    task automatic test_pause();
        push_path(from_text("/home//u/./d/../bin"), 1'b0);
        wait_drain();
        push_path(from_text("..."), 1'b1);
        wait_drain();
    endtask

    task automatic test_random();
        char_q_t p;
        int      sent;
        int      parts;
        int      kind;
        int      seg_len;
        bit      zero_end;
        sent = 0;
        while (sent < 110)
        begin
            p.delete();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 12)) p.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    p.push_back(pn_pkg::CH_SLASH);
                parts = $urandom_range(1, 6);
                for (int i = 0; i < parts; i++)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind == 0)
                        p.push_back(pn_pkg::CH_DOT);
                    else if (kind == 1)
                    begin
                        p.push_back(pn_pkg::CH_DOT);
                        p.push_back(pn_pkg::CH_DOT);
                    end
                    else
                    begin
                        seg_len = $urandom_range(1, 6);
                        for (int j = 0; j < seg_len; j++)
                            p.push_back($urandom_range(0, 4) == 0 ? pn_pkg::CH_DOT
                                                                  : rand_plain());
                    end
                    if ($urandom_range(0, 14) == 0)
                        p.push_back(pn_pkg::CH_NONE);
                    if (i + 1 < parts || $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : 1)
                            p.push_back(pn_pkg::CH_SLASH);
                end
            end
            zero_end = ($urandom_range(0, 3) == 0);
            push_path(p, zero_end);
            sent += p.size() + zero_end;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.ch    = pn_pkg::CH_NONE;
        chars_if.last  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_store();
        test_full_stack();
        test_backpressure();
        test_pause();
        test_random();

        wait_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_words.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/pn_pkg.sv
hw/rtl/pn_ifs.sv
hw/rtl/pn_front.sv
hw/rtl/pn_queue.sv
hw/rtl/pn_back.sv
hw/rtl/pn_pack.sv
hw/rtl/path_normalizer.sv
tb/sv/tb.sv
